// ----- hdl/tcle_pkg.sv -----
// Shared definitions for the canonical line editor: character and code constants,
// configuration reset values, and the controller/datapath command and status structs.
// No dependencies.
package tcle_pkg;

  localparam int DEFAULT_LINE_DEPTH = 32;

  localparam logic [1:0] CFG_MODE   = 2'd0;
  localparam logic [1:0] CFG_ERASE  = 2'd1;
  localparam logic [1:0] CFG_INTR   = 2'd2;
  localparam logic [1:0] CFG_IGNORE = 2'd3;

  localparam logic [6:0]  MODE_RESET   = 7'd63;
  localparam logic [7:0]  ERASE_RESET  = 8'd8;
  localparam logic [7:0]  INTR_RESET   = 8'd3;
  localparam logic [47:0] IGNORE_RESET = 48'h1A111C150C04;

  localparam int F_CANON     = 0;
  localparam int F_ECHO      = 1;
  localparam int F_ECHO_ERA  = 2;
  localparam int F_ICRNL     = 3;
  localparam int F_OPOST     = 4;
  localparam int F_ONLCR     = 5;
  localparam int F_OCRNL     = 6;

  localparam logic [1:0] PORT_ECHO   = 2'd0;
  localparam logic [1:0] PORT_READ   = 2'd1;
  localparam logic [1:0] PORT_SIGNAL = 2'd2;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_AT    = 8'h40;

  typedef struct packed {
    logic capture;
    logic decode;
    logic emit_load;
    logic stream_load;
  } cmd_t;

  typedef struct packed {
    logic slot_free;
    logic dec_has_ent;
    logic dec_stream;
    logic has_stream;
    logic emit_final;
    logic stream_final;
  } sts_t;

endpackage

// ----- hdl/tty_canonical_line_editor_core.sv -----
// Top level of the terminal canonical line editor.
// Depends on tcle_pkg, tcle_ctrl and tcle_dp.
//
// The block takes one received byte per beat and returns its results one per beat, the
// final one marked by out_last. A byte is accepted and then classified in the following
// cycle; after that, results leave at one per cycle while out_ready stays high. An edit or
// echo byte has at most 6 results, when an interrupt byte's caret letter is itself a
// newline that expands to CR NL. A line end yields its echo (0 to 2 results) and then
// the stored line; the line store has a single read port and delivers one stored byte
// per cycle while out_ready stays high. The next byte is accepted as soon as the last
// result of the previous one sits in the output register. Configuration writes are
// always ready and are meant to be issued only while the block is idle.
module tty_canonical_line_editor_core #(
  parameter int LINE_DEPTH = tcle_pkg::DEFAULT_LINE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_port,
  output logic [7:0]  out_byte,
  output logic        out_last
);

  tcle_pkg::cmd_t cmd;
  tcle_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  tcle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts_i    (sts),
    .cmd_o    (cmd)
  );

  tcle_dp #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_byte   (in_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_port  (out_port),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .cmd_i     (cmd),
    .sts_o     (sts)
  );

endmodule

// ----- hdl/tcle_ctrl.sv -----
// Sequencing state machine for the canonical line editor.
// Depends on tcle_pkg for the command and status structs.
module tcle_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  tcle_pkg::sts_t sts_i,
  output tcle_pkg::cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_DECODE = 4'b0010,
    ST_EMIT   = 4'b0100,
    ST_STREAM = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd_o = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_o.capture = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd_o.decode = 1'b1;
        if (sts_i.dec_has_ent) begin
          state_nxt = ST_EMIT;
        end else if (sts_i.dec_stream) begin
          state_nxt = ST_STREAM;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (sts_i.slot_free) begin
          cmd_o.emit_load = 1'b1;
          if (sts_i.emit_final) begin
            state_nxt = sts_i.has_stream ? ST_STREAM : ST_IDLE;
          end
        end
      end
      ST_STREAM: begin
        if (sts_i.slot_free) begin
          cmd_o.stream_load = 1'b1;
          if (sts_i.stream_final) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // A new byte is only taken once every result of the previous one is loaded.
  a_capture_clean: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.capture |-> !(cmd_o.emit_load || cmd_o.stream_load || cmd_o.decode))
    else $error("capture overlaps result generation");

  // The decode step always follows a captured byte.
  a_decode_after_capture: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.capture |=> cmd_o.decode)
    else $error("decode did not follow capture");

  // A line end with echo off goes straight to streaming the line.
  a_stream_direct: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_o.decode && !sts_i.dec_has_ent && sts_i.dec_stream) |=> state_r == ST_STREAM)
    else $error("line delivery skipped");

endmodule

// ----- hdl/tcle_dp.sv -----
// Datapath of the canonical line editor: configuration registers, line store,
// echo entry list with output post-processing, and the output register.
// Depends on tcle_pkg.
module tcle_dp #(
  parameter int LINE_DEPTH = tcle_pkg::DEFAULT_LINE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_valid,
  input  logic [1:0]     cfg_index,
  input  logic [47:0]    cfg_data,
  input  logic [7:0]     in_byte,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [1:0]     out_port,
  output logic [7:0]     out_byte,
  output logic           out_last,
  input  tcle_pkg::cmd_t cmd_i,
  output tcle_pkg::sts_t sts_o
);

  localparam int FILL_W = $clog2(LINE_DEPTH + 1);
  localparam int ADDR_W = $clog2(LINE_DEPTH);

  logic [6:0]  flags_r;
  logic [7:0]  erase_r;
  logic [7:0]  intr_r;
  logic [47:0] ign_r;

  logic [7:0]        byte_r;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [FILL_W-1:0] stream_len_r, stream_len_nxt;
  logic [ADDR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [7:0]        rdata_r;
  logic [7:0]        mem [LINE_DEPTH];

  logic [1:0] ent_port_r [4];
  logic [7:0] ent_byte_r [4];
  logic [2:0] ent_cnt_r;
  logic [1:0] ent_idx_r;
  logic       sub_r;
  logic       stream_r;

  logic       out_valid_r;
  logic [1:0] out_port_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;

  logic [1:0] d_port [4];
  logic [7:0] d_byte [4];
  logic [2:0] d_cnt;
  logic       d_stream;
  logic       we;
  logic [7:0] wdata;
  logic [7:0] vis0, vis1;
  logic [2:0] vis_cnt;
  logic       ign_lo, ign_hi, is_erase, is_intr, is_eol;

  logic [1:0] cur_port;
  logic [7:0] cur_byte;
  logic [7:0] emit_byte;
  logic       split_first;
  logic       emit_final;
  logic       stream_final;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= tcle_pkg::MODE_RESET;
      erase_r <= tcle_pkg::ERASE_RESET;
      intr_r  <= tcle_pkg::INTR_RESET;
      ign_r   <= tcle_pkg::IGNORE_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tcle_pkg::CFG_MODE:   flags_r <= cfg_data[6:0];
        tcle_pkg::CFG_ERASE:  erase_r <= cfg_data[7:0];
        tcle_pkg::CFG_INTR:   intr_r  <= cfg_data[7:0];
        tcle_pkg::CFG_IGNORE: ign_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    ign_lo   = (byte_r == ign_r[7:0]) || (byte_r == ign_r[15:8]);
    ign_hi   = (byte_r == ign_r[23:16]) || (byte_r == ign_r[31:24]) ||
               (byte_r == ign_r[39:32]) || (byte_r == ign_r[47:40]);
    is_erase = (byte_r == erase_r) || (byte_r == tcle_pkg::CH_BS);
    is_intr  = (byte_r == intr_r);
    is_eol   = (byte_r == tcle_pkg::CH_NL) ||
               ((byte_r == tcle_pkg::CH_CR) && flags_r[tcle_pkg::F_ICRNL]);
    if (byte_r < tcle_pkg::CH_SP) begin
      vis0    = tcle_pkg::CH_CARET;
      vis1    = byte_r + tcle_pkg::CH_AT;
      vis_cnt = 3'd2;
    end else begin
      vis0    = byte_r;
      vis1    = byte_r;
      vis_cnt = 3'd1;
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      d_port[i] = tcle_pkg::PORT_ECHO;
      d_byte[i] = 8'd0;
    end
    d_cnt          = 3'd0;
    d_stream       = 1'b0;
    we             = 1'b0;
    wdata          = byte_r;
    fill_nxt       = fill_r;
    stream_len_nxt = stream_len_r;
    if (!flags_r[tcle_pkg::F_CANON]) begin
      d_port[0] = tcle_pkg::PORT_READ;
      d_byte[0] = byte_r;
      d_cnt     = 3'd1;
    end else if (ign_lo || (!is_erase && !is_intr && ign_hi)) begin
      if (flags_r[tcle_pkg::F_ECHO]) begin
        d_byte[0] = vis0;
        d_byte[1] = vis1;
        d_cnt     = vis_cnt;
      end
    end else if (is_erase) begin
      if (fill_r != '0) begin
        fill_nxt = fill_r - FILL_W'(1);
        if (flags_r[tcle_pkg::F_ECHO_ERA]) begin
          d_byte[0] = tcle_pkg::CH_BS;
          d_byte[1] = tcle_pkg::CH_SP;
          d_byte[2] = tcle_pkg::CH_BS;
          d_cnt     = 3'd3;
        end
      end
    end else if (is_intr) begin
      d_port[0] = tcle_pkg::PORT_SIGNAL;
      d_byte[1] = tcle_pkg::CH_CARET;
      d_byte[2] = byte_r + tcle_pkg::CH_AT;
      d_byte[3] = tcle_pkg::CH_NL;
      d_cnt     = 3'd4;
    end else if (is_eol) begin
      we             = 1'b1;
      wdata          = tcle_pkg::CH_NL;
      stream_len_nxt = fill_r + FILL_W'(1);
      fill_nxt       = '0;
      d_stream       = 1'b1;
      if (flags_r[tcle_pkg::F_ECHO]) begin
        d_byte[0] = tcle_pkg::CH_NL;
        d_cnt     = 3'd1;
      end
    end else if (fill_r < FILL_W'(LINE_DEPTH - 1)) begin
      we       = 1'b1;
      fill_nxt = fill_r + FILL_W'(1);
      if (flags_r[tcle_pkg::F_ECHO]) begin
        d_byte[0] = vis0;
        d_byte[1] = vis1;
        d_cnt     = vis_cnt;
      end
    end
  end

  always_comb begin
    cur_port    = ent_port_r[ent_idx_r];
    cur_byte    = ent_byte_r[ent_idx_r];
    split_first = (cur_port == tcle_pkg::PORT_ECHO) && flags_r[tcle_pkg::F_OPOST] &&
                  (cur_byte == tcle_pkg::CH_NL) && flags_r[tcle_pkg::F_ONLCR] && !sub_r;
    emit_byte   = cur_byte;
    if ((cur_port == tcle_pkg::PORT_ECHO) && flags_r[tcle_pkg::F_OPOST]) begin
      if ((cur_byte == tcle_pkg::CH_NL) && flags_r[tcle_pkg::F_ONLCR]) begin
        emit_byte = sub_r ? tcle_pkg::CH_NL : tcle_pkg::CH_CR;
      end else if ((cur_byte == tcle_pkg::CH_CR) && flags_r[tcle_pkg::F_OCRNL]) begin
        emit_byte = tcle_pkg::CH_NL;
      end
    end
    emit_final   = ({1'b0, ent_idx_r} == (ent_cnt_r - 3'd1)) && !split_first;
    stream_final = (FILL_W'(rd_ptr_r) == (stream_len_r - FILL_W'(1)));
    if (cmd_i.decode) begin
      rd_ptr_nxt = '0;
    end else if (cmd_i.stream_load && !stream_final) begin
      rd_ptr_nxt = rd_ptr_r + ADDR_W'(1);
    end else begin
      rd_ptr_nxt = rd_ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.decode && we) begin
      mem[fill_r[ADDR_W-1:0]] <= wdata;
    end
    if (cmd_i.decode && we && (fill_r[ADDR_W-1:0] == rd_ptr_nxt)) begin
      rdata_r <= wdata;
    end else begin
      rdata_r <= mem[rd_ptr_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.capture) begin
      byte_r <= in_byte;
    end
    if (cmd_i.decode) begin
      for (int i = 0; i < 4; i++) begin
        ent_port_r[i] <= d_port[i];
        ent_byte_r[i] <= d_byte[i];
      end
      ent_cnt_r    <= d_cnt;
      stream_len_r <= stream_len_nxt;
    end
    if (cmd_i.emit_load) begin
      out_port_r <= cur_port;
      out_byte_r <= emit_byte;
      out_last_r <= emit_final && !stream_r;
    end else if (cmd_i.stream_load) begin
      out_port_r <= tcle_pkg::PORT_READ;
      out_byte_r <= rdata_r;
      out_last_r <= stream_final;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      rd_ptr_r    <= '0;
      ent_idx_r   <= '0;
      sub_r       <= 1'b0;
      stream_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      if (cmd_i.decode) begin
        fill_r    <= fill_nxt;
        ent_idx_r <= '0;
        sub_r     <= 1'b0;
        stream_r  <= d_stream;
      end else if (cmd_i.emit_load) begin
        if (split_first) begin
          sub_r <= 1'b1;
        end else begin
          sub_r     <= 1'b0;
          ent_idx_r <= ent_idx_r + 2'd1;
        end
      end
      if (cmd_i.emit_load || cmd_i.stream_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    sts_o.slot_free    = !out_valid_r || out_ready;
    sts_o.dec_has_ent  = (d_cnt != 3'd0);
    sts_o.dec_stream   = d_stream;
    sts_o.has_stream   = stream_r;
    sts_o.emit_final   = emit_final;
    sts_o.stream_final = stream_final;
  end

  assign out_valid = out_valid_r;
  assign out_port  = out_port_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

  // A result is never loaded over one that the consumer has not taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_i.emit_load || cmd_i.stream_load) |-> (!out_valid_r || out_ready))
    else $error("output register overwritten");

  // Between lines the store always keeps its last slot free for the line end.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(LINE_DEPTH - 1))
    else $error("line store overfilled");

  // Streaming never reads past the delivered line.
  a_stream_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.stream_load |-> (FILL_W'(rd_ptr_r) < stream_len_r))
    else $error("stream pointer past line end");

endmodule

// ----- sim/tcle_line_checker.sv -----
// Watches the configuration, byte and result channels of the canonical line editor,
// keeps its own copy of the editor state and compares every result beat in order.
// Depends on tcle_pkg.
`timescale 1ns / 1ps
module tcle_line_checker #(
  parameter int LINE_DEPTH = tcle_pkg::DEFAULT_LINE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_port,
  input  logic [7:0]  out_byte,
  input  logic        out_last,
  output int          mismatches,
  output int          pending
);

  typedef struct packed {
    logic [1:0] port;
    logic [7:0] data;
    logic       last;
  } beat_t;

  beat_t       awaited_beats[$];
  logic [7:0]  line_buf[LINE_DEPTH];
  int          line_len;
  int          fail_cnt = 0;
  logic [6:0]  mode;
  logic [7:0]  erase_ch;
  logic [7:0]  intr_ch;
  logic [47:0] swallow_set;

  function automatic void add_beat(input logic [1:0] p, input logic [7:0] d);
    beat_t b;
    b.port = p;
    b.data = d;
    b.last = 1'b0;
    awaited_beats.push_back(b);
  endfunction

  function automatic void echo_post(input logic [7:0] c);
    if (mode[tcle_pkg::F_OPOST] && c == tcle_pkg::CH_NL && mode[tcle_pkg::F_ONLCR]) begin
      add_beat(tcle_pkg::PORT_ECHO, tcle_pkg::CH_CR);
      add_beat(tcle_pkg::PORT_ECHO, tcle_pkg::CH_NL);
    end else if (mode[tcle_pkg::F_OPOST] && c == tcle_pkg::CH_CR &&
                 mode[tcle_pkg::F_OCRNL]) begin
      add_beat(tcle_pkg::PORT_ECHO, tcle_pkg::CH_NL);
    end else begin
      add_beat(tcle_pkg::PORT_ECHO, c);
    end
  endfunction

  function automatic void echo_caret(input logic [7:0] c);
    if (c < tcle_pkg::CH_SP) begin
      echo_post(tcle_pkg::CH_CARET);
      echo_post(c + tcle_pkg::CH_AT);
    end else begin
      echo_post(c);
    end
  endfunction

  function automatic logic swallowed(input logic [7:0] c, input int slot);
    return swallow_set[8*slot +: 8] == c;
  endfunction

  function automatic void apply_rx_byte(input logic [7:0] c);
    int    base;
    beat_t b;
    base = awaited_beats.size();
    if (!mode[tcle_pkg::F_CANON]) begin
      add_beat(tcle_pkg::PORT_READ, c);
    end else if (swallowed(c, 0) || swallowed(c, 1)) begin
      if (mode[tcle_pkg::F_ECHO]) echo_caret(c);
    end else if (c == erase_ch || c == tcle_pkg::CH_BS) begin
      if (line_len > 0) begin
        line_len--;
        if (mode[tcle_pkg::F_ECHO_ERA]) begin
          echo_post(tcle_pkg::CH_BS);
          echo_post(tcle_pkg::CH_SP);
          echo_post(tcle_pkg::CH_BS);
        end
      end
    end else if (c == intr_ch) begin
      add_beat(tcle_pkg::PORT_SIGNAL, 8'h00);
      echo_post(tcle_pkg::CH_CARET);
      echo_post(c + tcle_pkg::CH_AT);
      echo_post(tcle_pkg::CH_NL);
    end else if (swallowed(c, 2) || swallowed(c, 3) || swallowed(c, 4) ||
                 swallowed(c, 5)) begin
      if (mode[tcle_pkg::F_ECHO]) echo_caret(c);
    end else if (c == tcle_pkg::CH_NL || (c == tcle_pkg::CH_CR && mode[tcle_pkg::F_ICRNL])) begin
      line_buf[line_len] = tcle_pkg::CH_NL;
      line_len++;
      if (mode[tcle_pkg::F_ECHO]) echo_post(tcle_pkg::CH_NL);
      for (int k = 0; k < line_len; k++) add_beat(tcle_pkg::PORT_READ, line_buf[k]);
      line_len = 0;
    end else if (line_len < LINE_DEPTH - 1) begin
      line_buf[line_len] = c;
      line_len++;
      if (mode[tcle_pkg::F_ECHO]) echo_caret(c);
    end
    if (awaited_beats.size() > base) begin
      b = awaited_beats.pop_back();
      b.last = 1'b1;
      awaited_beats.push_back(b);
    end
  endfunction

  always @(posedge clk) begin
    beat_t got;
    beat_t want;
    if (!rst_n) begin
      awaited_beats.delete();
      line_len    = 0;
      mode        = tcle_pkg::MODE_RESET;
      erase_ch    = tcle_pkg::ERASE_RESET;
      intr_ch     = tcle_pkg::INTR_RESET;
      swallow_set = tcle_pkg::IGNORE_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tcle_pkg::CFG_MODE:   mode = cfg_data[6:0];
          tcle_pkg::CFG_ERASE:  erase_ch = cfg_data[7:0];
          tcle_pkg::CFG_INTR:   intr_ch = cfg_data[7:0];
          tcle_pkg::CFG_IGNORE: swallow_set = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        got.port = out_port;
        got.data = out_byte;
        got.last = out_last;
        if (awaited_beats.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("%0t: unexpected result beat port %0d byte %02h last %0b",
                     $realtime, got.port, got.data, got.last);
        end else begin
          want = awaited_beats.pop_front();
          if (got !== want) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display({"%0t: result beat expected port %0d byte %02h last %0b, ",
                        "got port %0d byte %02h last %0b"},
                       $realtime, want.port, want.data, want.last,
                       got.port, got.data, got.last);
          end
        end
      end
      if (in_valid && in_ready) apply_rx_byte(in_byte);
    end
    mismatches <= fail_cnt;
    pending    <= awaited_beats.size();
  end

endmodule

// ----- sim/tb_tty_canonical_line_editor_core.sv -----
// Testbench top for the canonical line editor: clock, reset, configuration phases and
// randomized byte traffic with stalls on both channels; the verdict comes from
// tcle_line_checker. Depends on tcle_pkg, tcle_line_checker and the editor RTL.
`timescale 1ns / 1ps
module tb_tty_canonical_line_editor_core;

  localparam int LINE_DEPTH    = tcle_pkg::DEFAULT_LINE_DEPTH;
  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_LIMIT   = 2000;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = tcle_pkg::CFG_MODE;
  logic [47:0] cfg_data  = '0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_port;
  logic [7:0]  out_byte;
  logic        out_last;

  int          mismatches;
  int          pending;
  int          sent      = 0;
  logic        tx_pause  = 1'b1;
  logic        rx_pause  = 1'b1;
  logic [7:0]  cur_erase = tcle_pkg::ERASE_RESET;
  logic [7:0]  cur_intr  = tcle_pkg::INTR_RESET;
  logic [47:0] cur_swallow = tcle_pkg::IGNORE_RESET;

  logic [7:0]  opening_bytes[$] = '{8'h08, 8'h61, 8'h00, 8'h1F, 8'h7F, 8'h80, 8'hFF,
                                    8'h08, 8'h04, 8'h0C, 8'h15, 8'h1C, 8'h11, 8'h1A,
                                    8'h03, 8'h0D, 8'h78, 8'h0A, 8'h0A};

  always #5 clk = ~clk;

  tty_canonical_line_editor_core #(.LINE_DEPTH(LINE_DEPTH)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_byte(in_byte),
    .out_valid(out_valid), .out_ready(out_ready), .out_port(out_port),
    .out_byte(out_byte), .out_last(out_last)
  );

  tcle_line_checker #(.LINE_DEPTH(LINE_DEPTH)) i_checker (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_byte(in_byte),
    .out_valid(out_valid), .out_ready(out_ready), .out_port(out_port),
    .out_byte(out_byte), .out_last(out_last),
    .mismatches(mismatches), .pending(pending)
  );

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = tx_pause ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic drain(input int settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic put_reg(input logic [1:0] idx, input logic [47:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 19))
      0, 1:    return cur_erase;
      2:       return tcle_pkg::CH_BS;
      3:       return cur_intr;
      4, 5:    return cur_swallow[8*$urandom_range(0, 5) +: 8];
      6, 7:    return 8'($urandom_range(0, 255));
      default: return 8'($urandom_range(32, 126));
    endcase
  endfunction

  task automatic send_line();
    int len;
    len = ($urandom_range(0, 5) == 0) ? $urandom_range(26, 44) : $urandom_range(0, 12);
    for (int k = 0; k < len; k++) send_byte(pick_byte());
    case ($urandom_range(0, 9))
      0:       ;
      1, 2, 3: send_byte(tcle_pkg::CH_CR);
      default: send_byte(tcle_pkg::CH_NL);
    endcase
  endtask

  task automatic run_phase(input logic [6:0] m, input logic [7:0] e, input logic [7:0] i,
                           input logic [47:0] s, input int items);
    int target;
    drain(SETTLE_CYCLES);
    cur_erase   = e;
    cur_intr    = i;
    cur_swallow = s;
    put_reg(tcle_pkg::CFG_MODE, {41'b0, m});
    put_reg(tcle_pkg::CFG_ERASE, {40'b0, e});
    put_reg(tcle_pkg::CFG_INTR, {40'b0, i});
    put_reg(tcle_pkg::CFG_IGNORE, s);
    cfg_valid <= 1'b0;
    target = sent + items;
    while (sent < target) begin
      tx_pause = ($urandom_range(0, 3) != 0);
      rx_pause = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) == 0) drain(0);
      send_line();
    end
  endtask

  initial begin : result_sink
    int gap;
    while (!rst_n) @(posedge clk);
    forever begin
      gap = rx_pause ? $urandom_range(0, 17) : 0;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("tty_canonical_line_editor_core: mismatch");
    $finish;
  end

  initial begin : stimulus
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (opening_bytes[k]) send_byte(opening_bytes[k]);
    run_phase(7'h7F, 8'h7F, 8'hCD, tcle_pkg::IGNORE_RESET, 32);
    run_phase(7'h00, 8'hFF, 8'hFF, 48'hFFFF_FFFF_FFFF, 32);
    run_phase(7'h01, tcle_pkg::ERASE_RESET, tcle_pkg::INTR_RESET, tcle_pkg::IGNORE_RESET, 32);
    run_phase(7'h57, 8'h00, 8'hCA, 48'h0, 32);
    run_phase(7'h3B, 8'h7F, tcle_pkg::INTR_RESET, tcle_pkg::IGNORE_RESET, 32);
    run_phase(7'h0D, tcle_pkg::ERASE_RESET, tcle_pkg::CH_NL, tcle_pkg::IGNORE_RESET, 32);
    repeat (4)
      run_phase(7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), 48'({$urandom, $urandom}), 32);
    drain(SETTLE_CYCLES);
    if (mismatches == 0 && pending == 0)
      $display("tty_canonical_line_editor_core: match");
    else
      $display("tty_canonical_line_editor_core: mismatch");
    $finish;
  end

endmodule
